// ===== rtl/core/cmkm_pkg.sv =====
`default_nettype none
package cmkm_pkg;

    localparam int NUM_CLASSES_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 24;

    localparam int CLASS_W   = 4;
    localparam int KIND_W    = 2;
    localparam int RATIO_W   = 17;
    localparam int KAPPA_W   = 18;
    localparam int TOTAL_W   = 24;
    localparam int FRAC_BITS = 16;

    localparam logic [RATIO_W-1:0] ONE_FX = 17'h10000;

    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLASS   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    typedef enum logic [2:0] {
        DS_OA,
        DS_KAP,
        DS_PA,
        DS_UA,
        DS_F1
    } t_dsel;

    typedef struct packed {
        logic              in_take;
        logic              acc_write;
        logic              walk_start;
        logic              chance_start;
        logic              clear_start;
        logic              div_start;
        logic              div_store;
        t_dsel             dsel;
        logic              out_load;
        logic [KIND_W-1:0] out_kind;
        logic              cls_next;
    } t_cmd;

    typedef struct packed {
        logic total_zero;
        logic walk_done;
        logic chance_done;
        logic clear_done;
        logic div_done;
        logic cls_observed;
        logic out_last;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/core/cmkm_div.sv =====
`default_nettype none
module cmkm_div
    import cmkm_pkg::*;
#(
    parameter int DW = 48
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DW-1:0]      i_num,
    input  wire logic [DW-1:0]      i_den,
    output logic                    o_done,
    output logic [RATIO_W-1:0]      o_res
);

    localparam int CNTW = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNTW-1:0]      r_cnt;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_den;
    logic [FRAC_BITS-1:0] r_q;
    logic [RATIO_W-1:0]   r_res;
    logic [DW:0]          n_rem2;
    logic                 n_ge;

    assign n_rem2 = {r_rem, 1'b0};
    assign n_ge   = n_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                if (i_den == '0) begin
                    r_res  <= '0;
                    r_done <= 1'b1;
                end else if (i_num >= i_den) begin
                    r_res  <= ONE_FX;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_num;
                    r_q    <= '0;
                    r_cnt  <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == CNTW'(FRAC_BITS)) begin
                    r_res  <= {1'b0, r_q} + RATIO_W'(n_ge);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_q   <= {r_q[FRAC_BITS-2:0], n_ge};
                    r_rem <= n_ge ? DW'(n_rem2 - {1'b0, r_den}) : DW'(n_rem2);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_res <= ONE_FX)
        else $error("Quotient exceeds one.");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("Divider started while busy.");

endmodule
`default_nettype wire

// ===== rtl/core/cmkm_dp.sv =====
`default_nettype none
module cmkm_dp
    import cmkm_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    output t_stat                           o_stat,
    input  wire logic [CLASS_W-1:0]         i_true_class,
    input  wire logic [CLASS_W-1:0]         i_predicted_class,
    output logic [KIND_W-1:0]               o_kind,
    output logic [CLASS_W-1:0]              o_class_number,
    output logic [RATIO_W-1:0]              o_overall_accuracy,
    output logic signed [KAPPA_W-1:0]       o_kappa,
    output logic [RATIO_W-1:0]              o_producer_accuracy,
    output logic [RATIO_W-1:0]              o_user_accuracy,
    output logic [RATIO_W-1:0]              o_f1_score,
    output logic [TOTAL_W-1:0]              o_sample_total,
    output logic                            o_saturated,
    output logic                            o_last
);

    localparam int CL    = (NUM_CLASSES < 16) ? NUM_CLASSES : 16;
    localparam int CIW   = $clog2(CL);
    localparam int CELLS = NUM_CLASSES * NUM_CLASSES;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = COUNT_WIDTH;
    localparam int PW    = 2 * COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    logic [CW-1:0] r_mem [CELLS];
    logic [CW-1:0] r_rdata;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_idx;
    logic [CW-1:0] r_samples;
    logic          r_sat;
    logic [AW-1:0] r_addr;
    logic          r_ok;

    logic           r_wbusy;
    logic [CIW-1:0] r_wt;
    logic [CIW-1:0] r_wp;
    logic           r_wv;
    logic           r_wlast;
    logic [CIW-1:0] r_wt_d;
    logic [CIW-1:0] r_wp_d;

    logic           r_cbusy;
    logic [CIW-1:0] r_ci;
    logic           r_pv;
    logic           r_plast;
    logic [CIW-1:0] r_cls;

    logic [CW-1:0] r_rows [CL];
    logic [CW-1:0] r_cols [CL];
    logic [CW-1:0] r_diag [CL];
    logic [CW-1:0] r_diag_sum;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_chance;
    logic [PW-1:0] r_dt;
    logic [PW-1:0] r_tt;

    logic [RATIO_W-1:0]        r_oa;
    logic signed [KAPPA_W-1:0] r_kap;
    logic [RATIO_W-1:0]        r_pa;
    logic [RATIO_W-1:0]        r_ua;

    logic [31:0]    n_acc_full;
    logic [31:0]    n_walk_full;
    logic           n_class_ok;
    logic [AW-1:0]  n_raddr;
    logic           n_we;
    logic [AW-1:0]  n_waddr;
    logic [CW-1:0]  n_wdata;
    logic           n_acc_sat;
    logic [CIW-1:0] n_ridx;
    logic [CIW-1:0] n_cidx;
    logic [CW-1:0]  n_row_rd;
    logic [CW-1:0]  n_col_rd;
    logic [CW-1:0]  n_diag_rd;
    logic [CL-1:0]  n_obs;
    logic [CL-1:0]  n_above;
    logic           n_kap_trivial;
    logic           n_kap_neg;
    logic [PW-1:0]  n_num;
    logic [PW-1:0]  n_den;
    logic           n_div_done;
    logic [RATIO_W-1:0] n_div_res;
    logic           n_wlast_now;
    logic           n_clast_now;

    assign n_acc_full  = 32'(i_true_class) * 32'(NUM_CLASSES) + 32'(i_predicted_class);
    assign n_walk_full = 32'(r_wt) * 32'(NUM_CLASSES) + 32'(r_wp);
    assign n_class_ok  = (32'(i_true_class) < 32'(NUM_CLASSES))
                      && (32'(i_predicted_class) < 32'(NUM_CLASSES));
    assign n_raddr     = r_wbusy ? n_walk_full[AW-1:0] : r_addr;
    assign n_acc_sat   = (r_samples == CNT_MAX) || (r_rdata == CNT_MAX);

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_addr;
        n_wdata = r_rdata + 1'b1;
        if (r_clr_busy) begin
            n_we    = 1'b1;
            n_waddr = r_clr_idx;
            n_wdata = '0;
        end else if (i_cmd.acc_write && r_ok && !n_acc_sat) begin
            n_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rdata <= r_mem[n_raddr];
    end

    assign n_ridx    = r_wv ? r_wt_d : (r_cbusy ? r_ci : r_cls);
    assign n_cidx    = r_wv ? r_wp_d : (r_cbusy ? r_ci : r_cls);
    assign n_row_rd  = r_rows[n_ridx];
    assign n_col_rd  = r_cols[n_cidx];
    assign n_diag_rd = r_diag[r_cls];

    always_comb begin
        for (int i = 0; i < CL; i++) begin
            n_obs[i] = (r_rows[i] != '0) || (r_cols[i] != '0);
        end
    end
    assign n_above = n_obs >> r_cls;

    assign n_wlast_now = (r_wt == CIW'(CL - 1)) && (r_wp == CIW'(CL - 1));
    assign n_clast_now = (r_ci == CIW'(CL - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_samples  <= '0;
            r_sat      <= 1'b0;
            r_wbusy    <= 1'b0;
            r_wv       <= 1'b0;
            r_cbusy    <= 1'b0;
            r_pv       <= 1'b0;
            r_cls      <= '0;
        end else begin
            if (i_cmd.clear_start) begin
                r_clr_busy <= 1'b1;
                r_clr_idx  <= '0;
                r_samples  <= '0;
                r_sat      <= 1'b0;
            end else if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cmd.acc_write && r_ok) begin
                if (n_acc_sat) begin
                    r_sat <= 1'b1;
                end else begin
                    r_samples <= r_samples + 1'b1;
                end
            end
            if (i_cmd.walk_start) begin
                r_wbusy <= 1'b1;
                r_wt    <= '0;
                r_wp    <= '0;
                r_cls   <= '0;
            end else if (r_wbusy) begin
                if (r_wp == CIW'(CL - 1)) begin
                    r_wp <= '0;
                    r_wt <= r_wt + 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
                if (n_wlast_now) begin
                    r_wbusy <= 1'b0;
                end
            end else if (i_cmd.cls_next) begin
                r_cls <= r_cls + 1'b1;
            end
            r_wv <= r_wbusy;
            if (i_cmd.chance_start) begin
                r_cbusy <= 1'b1;
                r_ci    <= '0;
            end else if (r_cbusy) begin
                r_ci <= r_ci + 1'b1;
                if (n_clast_now) begin
                    r_cbusy <= 1'b0;
                end
            end
            r_pv <= r_cbusy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_addr <= n_acc_full[AW-1:0];
            r_ok   <= n_class_ok;
        end
        r_wt_d  <= r_wt;
        r_wp_d  <= r_wp;
        r_wlast <= n_wlast_now;
        r_plast <= n_clast_now;
        if (i_cmd.walk_start) begin
            for (int i = 0; i < CL; i++) begin
                r_rows[i] <= '0;
                r_cols[i] <= '0;
                r_diag[i] <= '0;
            end
            r_diag_sum <= '0;
        end else if (r_wv) begin
            r_rows[r_wt_d] <= n_row_rd + r_rdata;
            r_cols[r_wp_d] <= n_col_rd + r_rdata;
            if (r_wt_d == r_wp_d) begin
                r_diag[r_wt_d] <= r_rdata;
                r_diag_sum     <= r_diag_sum + r_rdata;
            end
        end
        r_prod <= PW'(n_row_rd) * PW'(n_col_rd);
        if (i_cmd.chance_start) begin
            r_chance <= '0;
        end else if (r_pv) begin
            r_chance <= r_chance + r_prod;
        end
        r_dt <= PW'(r_diag_sum) * PW'(r_samples);
        r_tt <= PW'(r_samples) * PW'(r_samples);
    end

    assign n_kap_trivial = (r_diag_sum == r_samples) || (r_tt == r_chance);
    assign n_kap_neg     = r_dt < r_chance;

    always_comb begin
        unique case (i_cmd.dsel)
            DS_OA: begin
                n_num = PW'(r_diag_sum);
                n_den = PW'(r_samples);
            end
            DS_KAP: begin
                n_num = n_kap_neg ? (r_chance - r_dt) : (r_dt - r_chance);
                n_den = r_tt - r_chance;
            end
            DS_PA: begin
                n_num = PW'(n_diag_rd);
                n_den = PW'(n_row_rd);
            end
            DS_UA: begin
                n_num = PW'(n_diag_rd);
                n_den = PW'(n_col_rd);
            end
            DS_F1: begin
                n_num = PW'({n_diag_rd, 1'b0});
                n_den = PW'(n_row_rd) + PW'(n_col_rd);
            end
            default: begin
                n_num = '0;
                n_den = '0;
            end
        endcase
    end

    cmkm_div #(
        .DW(PW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (n_num),
        .i_den  (n_den),
        .o_done (n_div_done),
        .o_res  (n_div_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            unique case (i_cmd.dsel)
                DS_OA: begin
                    r_oa <= n_div_res;
                    if (n_kap_trivial) begin
                        r_kap <= {1'b0, ONE_FX};
                    end
                end
                DS_KAP: begin
                    if (!n_kap_trivial) begin
                        r_kap <= n_kap_neg ? (KAPPA_W'(0) - {1'b0, n_div_res})
                                           : {1'b0, n_div_res};
                    end
                end
                DS_PA: r_pa <= n_div_res;
                DS_UA: r_ua <= n_div_res;
                DS_F1: begin
                    o_f1_score <= n_div_res;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.out_load) begin
            o_kind         <= i_cmd.out_kind;
            o_sample_total <= TOTAL_W'(r_samples);
            o_saturated    <= r_sat;
            o_class_number      <= '0;
            o_overall_accuracy  <= '0;
            o_kappa             <= '0;
            o_producer_accuracy <= '0;
            o_user_accuracy     <= '0;
            unique case (i_cmd.out_kind)
                KIND_SUMMARY: begin
                    o_overall_accuracy <= r_oa;
                    o_kappa            <= r_kap;
                    o_last             <= (n_obs == '0);
                end
                KIND_CLASS: begin
                    o_class_number      <= CLASS_W'(r_cls);
                    o_producer_accuracy <= r_pa;
                    o_user_accuracy     <= r_ua;
                    o_last              <= ((n_above >> 1) == '0);
                end
                default: begin
                    o_sample_total <= '0;
                    o_last         <= 1'b1;
                end
            endcase
            if (i_cmd.out_kind != KIND_CLASS) begin
                o_f1_score <= '0;
            end
        end
    end

    assign o_stat.total_zero   = (r_samples == '0);
    assign o_stat.walk_done    = r_wv && r_wlast;
    assign o_stat.chance_done  = r_pv && r_plast;
    assign o_stat.clear_done   = r_clr_busy && (r_clr_idx == AW'(CELLS - 1));
    assign o_stat.div_done     = n_div_done;
    assign o_stat.cls_observed = n_obs[r_cls];
    assign o_stat.out_last     = o_last;

endmodule
`default_nettype wire

// ===== rtl/core/cmkm_ctrl.sv =====
`default_nettype none
module cmkm_ctrl
    import cmkm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_func,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_ACC_RD  = 10'b0000000100,
        S_ACC_WR  = 10'b0000001000,
        S_WALK    = 10'b0000010000,
        S_CHANCE  = 10'b0000100000,
        S_DGO     = 10'b0001000000,
        S_DWT     = 10'b0010000000,
        S_EMIT    = 10'b0100000000,
        S_OUTW    = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    t_dsel             r_dsel, n_dsel;
    logic [KIND_W-1:0] r_okind, n_okind;
    logic              r_chk, n_chk;

    always_comb begin
        n_state = r_state;
        n_dsel  = r_dsel;
        n_okind = r_okind;
        n_chk   = r_chk;
        o_cmd          = '0;
        o_cmd.dsel     = r_dsel;
        o_cmd.out_kind = r_okind;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    if (!i_func) begin
                        n_state = S_ACC_RD;
                    end else if (i_stat.total_zero) begin
                        n_okind = KIND_ERROR;
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_WALK;
                    end
                end
            end
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: begin
                o_cmd.acc_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    o_cmd.chance_start = 1'b1;
                    n_state            = S_CHANCE;
                end
            end
            S_CHANCE: begin
                if (i_stat.chance_done) begin
                    n_dsel  = DS_OA;
                    n_state = S_DGO;
                end
            end
            S_DGO: begin
                if (r_chk) begin
                    if (i_stat.cls_observed) begin
                        n_chk   = 1'b0;
                        n_dsel  = DS_PA;
                    end else begin
                        o_cmd.cls_next = 1'b1;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DWT;
                end
            end
            S_DWT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = S_DGO;
                    unique case (r_dsel)
                        DS_OA: begin
                            n_dsel = DS_KAP;
                        end
                        DS_PA: n_dsel = DS_UA;
                        DS_UA: n_dsel = DS_F1;
                        DS_F1: begin
                            n_okind = KIND_CLASS;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_okind = KIND_SUMMARY;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUTW;
            end
            S_OUTW: begin
                if (i_out_ready) begin
                    if (i_stat.out_last) begin
                        o_cmd.clear_start = 1'b1;
                        n_state           = S_CLEAR;
                    end else begin
                        if (r_okind == KIND_CLASS) begin
                            o_cmd.cls_next = 1'b1;
                        end
                        n_chk   = 1'b1;
                        n_state = S_DGO;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_dsel  <= DS_OA;
            r_okind <= KIND_SUMMARY;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dsel  <= n_dsel;
            r_okind <= n_okind;
            r_chk   <= n_chk;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUTW);

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("Input and output sides active together.");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == S_DWT)
        else $error("Quotient arrived outside the wait state.");

    a_clear_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.clear_done |-> r_state == S_CLEAR)
        else $error("Clearing pass ended outside the clear state.");

endmodule
`default_nettype wire

// ===== rtl/core/confusion_matrix_kappa_metrics_core.sv =====
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_ready    | i_func, i_true_class, i_predicted_class
// output   | out       | o_out_valid / i_out_ready  | o_kind .. o_last
//
// A sample transaction steps through accept, matrix read and matrix write.
// A finish walks the matrix (one cell per cycle), sums chance terms, then
// runs the shared serial divider once per ratio: two ratios for the summary
// and three per observed class.
// After reset and after every report a clearing pass writes all
// NUM_CLASSES * NUM_CLASSES cells, one per cycle, while no input is taken.
// A stalled output holds the block; input is taken only when no result waits.
`default_nettype none
module confusion_matrix_kappa_metrics_core
    import cmkm_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_func,
    input  wire logic [CLASS_W-1:0]   i_true_class,
    input  wire logic [CLASS_W-1:0]   i_predicted_class,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [KIND_W-1:0]         o_kind,
    output logic [CLASS_W-1:0]        o_class_number,
    output logic [RATIO_W-1:0]        o_overall_accuracy,
    output logic signed [KAPPA_W-1:0] o_kappa,
    output logic [RATIO_W-1:0]        o_producer_accuracy,
    output logic [RATIO_W-1:0]        o_user_accuracy,
    output logic [RATIO_W-1:0]        o_f1_score,
    output logic [TOTAL_W-1:0]        o_sample_total,
    output logic                      o_saturated,
    output logic                      o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    cmkm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    cmkm_dp #(
        .NUM_CLASSES(NUM_CLASSES),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_true_class       (i_true_class),
        .i_predicted_class  (i_predicted_class),
        .o_kind             (o_kind),
        .o_class_number     (o_class_number),
        .o_overall_accuracy (o_overall_accuracy),
        .o_kappa            (o_kappa),
        .o_producer_accuracy(o_producer_accuracy),
        .o_user_accuracy    (o_user_accuracy),
        .o_f1_score         (o_f1_score),
        .o_sample_total     (o_sample_total),
        .o_saturated        (o_saturated),
        .o_last             (o_last)
    );

endmodule
`default_nettype wire
